// File: rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and types of the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

  // Default batch capacity.
  localparam int unsigned MAX_ITEMS_DEF = 64;

  // Width of one element.
  localparam int unsigned DATA_W = 32;

  // Status from the merge sequencer to the top level.
  typedef struct packed {
    logic done;   // sort finished, result sits in the store named by src_b
    logic wr_en;  // write the merged element into the destination store
    logic src_b;  // current source is the scratch store
  } merge_stat_t;

endpackage

// File: rtl/merge_sort_engine.sv
// Loading: items are taken only in the load state; the item marked last starts the sort.
// Sort: ceil(log2 N) passes, each element going through the shared comparator as a
//   registered store read, then a compare and write.
// Results: each is read from the store and held until taken, and the next is read only
//   after that; no new item is taken from the end of a batch until its last result leaves.
// Reset clears the control state and counts; the element stores are not cleared.
// ----------------------------------------------------------------------------
// merge_sort_engine
// Collects a batch of signed values, sorts it stably with bottom-up merge
// passes between two stores, and emits the values in ascending order.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
  parameter int unsigned MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [mse_pkg::DATA_W-1:0] value_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mse_pkg::DATA_W-1:0] sorted_value_o,
  output logic                              final_res_o,
  output logic                              overflowed_o
);

  import mse_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SORT,
    S_RD,
    S_LD,
    S_OUT
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     count_q;
  logic                 ovf_q;
  logic [CNT_W-1:0]     k_q;
  logic                 start_q;
  logic                 res_b_q;
  logic                 out_valid_q;
  logic                 final_q;
  logic signed [DATA_W-1:0] sorted_q;

  logic                 in_acc;
  logic                 out_acc;
  logic                 has_room;

  merge_stat_t          mstat;
  logic [ADDR_W-1:0]    m_rd_a;
  logic [ADDR_W-1:0]    m_rd_b;
  logic [ADDR_W-1:0]    m_wr_addr;
  logic signed [DATA_W-1:0] m_wr_data;

  logic                 a_we;
  logic [ADDR_W-1:0]    a_waddr;
  logic [DATA_W-1:0]    a_wdata;
  logic                 b_we;
  logic [ADDR_W-1:0]    rd_addr0;
  logic [DATA_W-1:0]    a_rd0;
  logic [DATA_W-1:0]    a_rd1;
  logic [DATA_W-1:0]    b_rd0;
  logic [DATA_W-1:0]    b_rd1;
  logic signed [DATA_W-1:0] src_rd0;
  logic signed [DATA_W-1:0] src_rd1;

  assign in_ready_o     = (state_q == S_LOAD);
  assign in_acc         = in_valid_i && in_ready_o;
  assign out_acc        = out_valid_q && out_ready_i;
  assign has_room       = (count_q < CNT_W'(MAX_ITEMS));
  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = sorted_q;
  assign final_res_o    = final_q;
  assign overflowed_o   = ovf_q;

  // Route store ports between loading, merging and readout
  always_comb begin
    if (state_q == S_LOAD) begin
      a_we    = in_acc && has_room;
      a_waddr = count_q[ADDR_W-1:0];
      a_wdata = value_i;
    end else begin
      a_we    = mstat.wr_en && mstat.src_b;
      a_waddr = m_wr_addr;
      a_wdata = m_wr_data;
    end
    b_we     = mstat.wr_en && !mstat.src_b;
    rd_addr0 = (state_q == S_SORT) ? m_rd_a : k_q[ADDR_W-1:0];
    src_rd0  = mstat.src_b ? $signed(b_rd0) : $signed(a_rd0);
    src_rd1  = mstat.src_b ? $signed(b_rd1) : $signed(a_rd1);
  end

  mse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_elem_ram (
    .clk_i    (clk_i),
    .we_i     (a_we),
    .waddr_i  (a_waddr),
    .wdata_i  (a_wdata),
    .raddr0_i (rd_addr0),
    .raddr1_i (m_rd_b),
    .rdata0_o (a_rd0),
    .rdata1_o (a_rd1)
  );

  mse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_scratch_ram (
    .clk_i    (clk_i),
    .we_i     (b_we),
    .waddr_i  (m_wr_addr),
    .wdata_i  (m_wr_data),
    .raddr0_i (rd_addr0),
    .raddr1_i (m_rd_b),
    .rdata0_o (b_rd0),
    .rdata1_o (b_rd1)
  );

  mse_merger #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_merger (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .count_i     (count_q),
    .rdata_a_i   (src_rd0),
    .rdata_b_i   (src_rd1),
    .rd_addr_a_o (m_rd_a),
    .rd_addr_b_o (m_rd_b),
    .wr_addr_o   (m_wr_addr),
    .wr_data_o   (m_wr_data),
    .stat_o      (mstat)
  );

  // Load items, run the sort, then hand out one result at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      k_q         <= '0;
      start_q     <= 1'b0;
      res_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
      final_q     <= 1'b0;
      sorted_q    <= '0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            // drop items past capacity and flag the batch
            if (has_room) begin
              count_q <= count_q + CNT_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_i) begin
              start_q <= 1'b1;
              state_q <= S_SORT;
            end
          end
        end
        S_SORT: begin
          if (mstat.done) begin
            res_b_q <= mstat.src_b;
            k_q     <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_LD;
        end
        S_LD: begin
          sorted_q    <= res_b_q ? $signed(b_rd0) : $signed(a_rd0);
          final_q     <= (k_q + CNT_W'(1) == count_q);
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (final_q) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              k_q     <= k_q + CNT_W'(1);
              state_q <= S_RD;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  // Never take items while results are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  // Fill count stays within capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("element count above capacity");

  // Merge writes only happen during the sort
  a_wr_in_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mstat.wr_en |-> (state_q == S_SORT))
    else $error("merge write outside the sort phase");

  // The final result closes the batch
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && final_q) |=> (count_q == '0) && !ovf_q && in_ready_o)
    else $error("batch not cleared after its final result");

endmodule

// File: rtl/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, read two, registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

// File: rtl/mse_merger.sv
// ----------------------------------------------------------------------------
// mse_merger
// Bottom-up merge sequencer: walks passes and runs, drives the two read
// addresses, and picks one element per step with the shared comparator.
// ----------------------------------------------------------------------------
module mse_merger #(
  parameter int unsigned MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]      count_i,
  input  logic signed [mse_pkg::DATA_W-1:0]   rdata_a_i,
  input  logic signed [mse_pkg::DATA_W-1:0]   rdata_b_i,
  output logic [$clog2(MAX_ITEMS)-1:0]        rd_addr_a_o,
  output logic [$clog2(MAX_ITEMS)-1:0]        rd_addr_b_o,
  output logic [$clog2(MAX_ITEMS)-1:0]        wr_addr_o,
  output logic signed [mse_pkg::DATA_W-1:0]   wr_data_o,
  output mse_pkg::merge_stat_t                stat_o
);

  import mse_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
  localparam int unsigned RUN_W  = CNT_W + 2;

  typedef enum logic [1:0] {
    M_IDLE,
    M_READ,
    M_MERGE
  } mstate_e;

  mstate_e           state_q;
  logic [CNT_W-1:0]  n_q;
  logic [RUN_W-1:0]  w_q;
  logic [RUN_W-1:0]  lo_q;
  logic [CNT_W-1:0]  mid_q;
  logic [CNT_W-1:0]  hi_q;
  logic [CNT_W-1:0]  a_q;
  logic [CNT_W-1:0]  b_q;
  logic [CNT_W-1:0]  k_q;
  logic              src_b_q;
  logic              done_q;

  logic              take_a;
  logic [CNT_W-1:0]  k_inc;
  logic              run_end;
  logic [RUN_W-1:0]  nlo;
  logic [RUN_W-1:0]  nw;
  logic              pass_end;
  logic              done_all;
  logic [CNT_W-1:0]  n_sel;
  logic [RUN_W-1:0]  n_ext;
  logic [RUN_W-1:0]  set_lo;
  logic [RUN_W-1:0]  set_w;
  logic [RUN_W-1:0]  mid_raw;
  logic [RUN_W-1:0]  hi_raw;
  logic [CNT_W-1:0]  set_mid;
  logic [CNT_W-1:0]  set_hi;

  // Compare the two run heads; ties go to the left run
  always_comb begin
    take_a    = (a_q < mid_q) && ((b_q >= hi_q) || (rdata_a_i <= rdata_b_i));
    wr_data_o = take_a ? rdata_a_i : rdata_b_i;
    k_inc     = k_q + CNT_W'(1);
    run_end   = (k_inc == hi_q);
    nlo       = lo_q + (w_q << 1);
    nw        = w_q << 1;
    pass_end  = (nlo >= RUN_W'(n_q));
    done_all  = pass_end && (nw >= RUN_W'(n_q));
  end

  // Bounds of the next run, clamped to the batch size
  always_comb begin
    if (state_q == M_IDLE) begin
      n_sel  = count_i;
      set_lo = '0;
      set_w  = RUN_W'(1);
    end else begin
      n_sel  = n_q;
      set_lo = pass_end ? '0 : nlo;
      set_w  = pass_end ? nw : w_q;
    end
    n_ext   = RUN_W'(n_sel);
    mid_raw = set_lo + set_w;
    hi_raw  = set_lo + (set_w << 1);
    set_mid = (mid_raw > n_ext) ? n_sel : mid_raw[CNT_W-1:0];
    set_hi  = (hi_raw > n_ext) ? n_sel : hi_raw[CNT_W-1:0];
  end

  assign rd_addr_a_o  = a_q[ADDR_W-1:0];
  assign rd_addr_b_o  = b_q[ADDR_W-1:0];
  assign wr_addr_o    = k_q[ADDR_W-1:0];
  assign stat_o.done  = done_q;
  assign stat_o.wr_en = (state_q == M_MERGE);
  assign stat_o.src_b = src_b_q;

  // Sequence passes and runs; each element is read in M_READ and written in M_MERGE
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      n_q     <= '0;
      w_q     <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      k_q     <= '0;
      src_b_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            n_q     <= count_i;
            src_b_q <= 1'b0;
            w_q     <= set_w;
            lo_q    <= set_lo;
            mid_q   <= set_mid;
            hi_q    <= set_hi;
            a_q     <= '0;
            b_q     <= set_mid;
            k_q     <= '0;
            if (count_i > CNT_W'(1)) begin
              state_q <= M_READ;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        M_READ: begin
          state_q <= M_MERGE;
        end
        M_MERGE: begin
          state_q <= M_READ;
          if (take_a) begin
            a_q <= a_q + CNT_W'(1);
          end else begin
            b_q <= b_q + CNT_W'(1);
          end
          k_q <= k_inc;
          if (run_end) begin
            if (pass_end) begin
              src_b_q <= ~src_b_q;
            end
            if (done_all) begin
              state_q <= M_IDLE;
              done_q  <= 1'b1;
            end else begin
              lo_q  <= set_lo;
              w_q   <= set_w;
              mid_q <= set_mid;
              hi_q  <= set_hi;
              a_q   <= set_lo[CNT_W-1:0];
              b_q   <= set_mid;
              k_q   <= set_lo[CNT_W-1:0];
            end
          end
        end
        default: begin
          state_q <= M_IDLE;
        end
      endcase
    end
  end

  // Merge step always writes inside the current run
  a_k_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == M_MERGE) |-> (k_q < hi_q) && (a_q <= mid_q) && (b_q <= hi_q))
    else $error("merge pointers left the current run");

  // Output index is always the run start plus the two consumed counts
  a_k_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != M_IDLE) |->
      (RUN_W'(k_q) + RUN_W'(mid_q) == RUN_W'(a_q) + RUN_W'(b_q)))
    else $error("merge output index out of step with run heads");

  // A run width never reaches the batch size while merging
  a_w_lt_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != M_IDLE) |-> (w_q < RUN_W'(n_q)))
    else $error("merge pass width not below batch size");

endmodule

// File: tb/tb_merge_sort_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_merge_sort_engine
// Feeds batches of signed values into the merge sort engine and checks that
// every batch comes back in ascending order, with the final element marked
// and the overflow flag set on batches that ran past the store capacity.
// Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_merge_sort_engine;

  import mse_pkg::*;

  localparam int unsigned CAPACITY    = MAX_ITEMS_DEF;
  localparam int          HALF_PERIOD = 10;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = 200;
  localparam int          RANDOM_ITEMS = 360;

  typedef logic signed [DATA_W-1:0] elem_t;

  // One input item as it goes onto the bus
  typedef struct {
    elem_t value;
    logic  last;
  } sort_item_t;

  // One result item as it should leave the block
  typedef struct {
    elem_t sorted_value;
    logic  final_res;
    logic  overflowed;
  } sorted_res_t;

  logic  clk_i          = 1'b0;
  logic  rst_ni         = 1'b0;
  logic  in_valid_i     = 1'b0;
  logic  in_ready_o;
  elem_t value_i        = '0;
  logic  last_i         = 1'b0;
  logic  out_valid_o;
  logic  out_ready_i    = 1'b0;
  elem_t sorted_value_o;
  logic  final_res_o;
  logic  overflowed_o;

  sort_item_t  pending_items[$];
  sorted_res_t expected_sorted[$];
  elem_t       batch_values[$];
  logic        batch_lost = 1'b0;

  logic        in_taken = 1'b0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  merge_sort_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .final_res_o   (final_res_o),
    .overflowed_o  (overflowed_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Collect one element into the current batch; on the end of a batch,
  // sort it stably and queue the ordered values as expected results.
  task automatic collect_element(input elem_t value, input logic last);
    elem_t       ordered[$];
    elem_t       key;
    sorted_res_t res;
    int          j;
    if (batch_values.size() < CAPACITY) begin
      batch_values.insert(batch_values.size(), value);
    end else begin
      batch_lost = 1'b1;
    end
    if (last) begin
      ordered = batch_values;
      for (int i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      foreach (ordered[k]) begin
        res.sorted_value = ordered[k];
        res.final_res    = (k == ordered.size() - 1);
        res.overflowed   = batch_lost;
        expected_sorted.insert(expected_sorted.size(), res);
      end
      batch_values.delete();
      batch_lost = 1'b0;
    end
  endtask

  // Queue a batch of values, marking the final one
  task automatic queue_batch(input elem_t vals[$]);
    sort_item_t item;
    foreach (vals[i]) begin
      item.value = vals[i];
      item.last  = (i == vals.size() - 1);
      pending_items.insert(pending_items.size(), item);
    end
  endtask

  // Draw an element, biased toward extremes and small values that repeat
  function automatic elem_t pick_element();
    case ($urandom_range(0, 5))
      0:       return elem_t'(32'h7FFF_FFFF - $urandom_range(0, 2));
      1:       return elem_t'(32'h8000_0000 + $urandom_range(0, 2));
      2:       return elem_t'($urandom_range(0, 8)) - elem_t'(4);
      default: return elem_t'($urandom());
    endcase
  endfunction

  // Drive input items: hold until taken, then burst or gap
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin : drive_items
    sort_item_t nxt;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        in_valid_i <= 1'b1;
        value_i    <= nxt.value;
        last_i     <= nxt.last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the output side on its own pattern, switching mode now and then
  int stall_mode = 0;
  int mode_left  = 0;
  int stall_tick = 0;

  always @(negedge clk_i) begin : drive_ready
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= stall_tick[2];
    endcase
  end

  // Sample both channels: predict on taken inputs, check taken results
  always @(posedge clk_i) begin : watch_ports
    sorted_res_t exp_res;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      collect_element(value_i, last_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_sorted.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: value %0d final %0b overflow %0b",
                   sorted_value_o, final_res_o, overflowed_o);
        end
        mismatch_count++;
      end else begin
        exp_res = expected_sorted.pop_front();
        if (sorted_value_o !== exp_res.sorted_value || final_res_o !== exp_res.final_res ||
            overflowed_o !== exp_res.overflowed) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected value %0d final %0b overflow %0b, got %0d %0b %0b",
                     exp_res.sorted_value, exp_res.final_res, exp_res.overflowed,
                     sorted_value_o, final_res_o, overflowed_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Build the stimulus, release reset, wait for the drain, report
  initial begin : run_test
    elem_t vals[$];
    int    n;
    int    queued;

    // Single-element batch at the negative extreme
    queue_batch('{elem_t'(32'h8000_0000)});
    // Extremes mixed with zero and the values around it
    queue_batch('{elem_t'(32'h7FFF_FFFF), elem_t'(32'h8000_0000), elem_t'(0),
                  elem_t'(-1), elem_t'(1), elem_t'(32'h7FFF_FFFF),
                  elem_t'(32'h8000_0000)});
    // Two equal values
    queue_batch('{elem_t'(5), elem_t'(5)});
    // Strictly descending run
    vals.delete();
    for (int i = 0; i < 8; i++) begin
      vals.insert(vals.size(), elem_t'(100 - 30 * i));
    end
    queue_batch(vals);

    // Random batches: mostly small, a few full, some past capacity
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       n = CAPACITY;
        1:       n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
        2:       n = CAPACITY - 1;
        default: n = $urandom_range(1, 12);
      endcase
      vals.delete();
      for (int i = 0; i < n; i++) begin
        vals.insert(vals.size(), pick_element());
      end
      queue_batch(vals);
      queued += n;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every item is sent and every result has come back
    do begin
      @(posedge clk_i);
    end while (pending_items.size() != 0 || in_valid_i || expected_sorted.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0 && expected_sorted.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
